// File: src/nfsa_pkg.sv
// Shared constants, codes, state and handshake types for the next-fit id allocator.
// No dependencies; imported by the datapath, the controller and the top level.
`default_nettype none

package nfsa_pkg;

  localparam int ID_W      = 16;
  localparam int ID_SPAN   = 1 << ID_W;
  localparam int FIELD_W   = 16;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int TDATA_W   = 24;

  // used-mark bitmap is stored as words; at least two words in the store
  localparam int WORD_W    = ((ID_SPAN / 2) < 32) ? (ID_SPAN / 2) : 32;
  localparam int WORD_BITS = $clog2(WORD_W);
  localparam int NWORDS    = ID_SPAN / WORD_W;
  localparam int WADDR_W   = ID_W - WORD_BITS;

  localparam logic [ID_W-1:0] ID_MAXV = '1;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLOSE  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_TOO_MANY  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_EVAL,
    S_SCAN,
    S_RESP
  } state_e_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic scan;
    logic eval;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_alloc;
    logic scan_done;
    logic out_free;
  } stat_t;

  // index of the lowest set bit
  function automatic logic [WORD_BITS-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [WORD_BITS-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = WORD_BITS'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/next_fit_search_id_allocator_top.sv
// Lookup/close: read of one bitmap word, check, result register.
// Allocate: scans 1 .. 2049 bitmap words of 32 ids; one word per
// cycle through the bitmap RAM read port. Next request is taken the cycle after the
// result enters the output register. Reset (synchronous, rst_n low) zeroes the pointer and
// starts a clearing pass over all 2048 bitmap words during which no request is taken.
// Depends on nfsa_pkg, nfsa_ctrl, nfsa_datapath, nfsa_ram.
`default_nettype none

module next_fit_search_id_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [1:0] operation, [17:2] search_id, rest zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [1:0] status, [17:2] assigned_id, rest zero
);
  import nfsa_pkg::*;

  cmd_t                cmd;
  stat_t               stat;
  logic [ST_W-1:0]     out_status;
  logic [FIELD_W-1:0]  out_id;

  nfsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nfsa_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_op     (in_tdata[OP_W-1:0]),
    .in_sid    (in_tdata[OP_W+FIELD_W-1:OP_W]),
    .out_tready(out_tready),
    .cmd       (cmd),
    .stat      (stat),
    .out_tvalid(out_tvalid),
    .out_status(out_status),
    .out_id    (out_id)
  );

  assign out_tdata = {(TDATA_W - ST_W - FIELD_W)'(0), out_id, out_status};

endmodule

`default_nettype wire

// File: src/nfsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: src/nfsa_datapath.sv
// Datapath: used-mark bitmap RAM, next-candidate pointer, word scan, result registers.
// Depends on nfsa_pkg and nfsa_ram; driven by nfsa_ctrl through cmd_t / stat_t.
`default_nettype none

module nfsa_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [nfsa_pkg::OP_W-1:0]    in_op,
  input  wire logic [nfsa_pkg::FIELD_W-1:0] in_sid,
  input  wire logic                        out_tready,
  input  wire nfsa_pkg::cmd_t               cmd,
  output nfsa_pkg::stat_t                   stat,
  output logic                             out_tvalid,
  output logic [nfsa_pkg::ST_W-1:0]         out_status,
  output logic [nfsa_pkg::FIELD_W-1:0]      out_id
);
  import nfsa_pkg::*;

  logic [OP_W-1:0]     op_r;
  logic [FIELD_W-1:0]  sid_r;
  logic [ID_W-1:0]     cand_r, cand_nxt;
  logic [WADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [WADDR_W-1:0]  rd_addr_r, rd_addr_nxt;
  logic [WADDR_W:0]    iss_cnt_r, iss_cnt_nxt;
  logic                ev_v_r, ev_v_nxt;
  logic [WADDR_W-1:0]  ev_addr_r, ev_addr_nxt;
  logic [WADDR_W:0]    ev_cnt_r, ev_cnt_nxt;
  logic [WORD_BITS-1:0] start_bit_r, start_bit_nxt;
  logic [ST_W-1:0]     res_status_r, res_status_nxt;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]     out_status_r;
  logic [FIELD_W-1:0]  out_id_r;

  logic [WORD_W-1:0]   ram_rdata;
  logic                wr_en;
  logic [WADDR_W-1:0]  wr_addr;
  logic [WORD_W-1:0]   wr_data;

  logic [ID_W-1:0]     start_cand;
  logic                issue;
  logic [WORD_W-1:0]   mask, free_bits;
  logic [WORD_BITS-1:0] enc;
  logic                hit, exhausted;
  logic [ID_W-1:0]     hit_id;
  logic [WORD_BITS-1:0] lbit;
  logic [WADDR_W-1:0]  lword;
  logic                beyond, look_ok;

  nfsa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NWORDS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr_r),
    .rd_data(ram_rdata)
  );

  always_comb begin
    start_cand = (cand_r == '0 || cand_r == ID_MAXV) ? ID_W'(1) : cand_r;

    // id 0 and the all-ones id are never free
    mask = '1;
    if (ev_addr_r == '0) mask[0] = 1'b0;
    if (ev_addr_r == WADDR_W'(NWORDS - 1)) mask[WORD_W-1] = 1'b0;
    if (ev_cnt_r == '0) mask = mask & ({WORD_W{1'b1}} << start_bit_r);
    free_bits = ~ram_rdata & mask;
    enc       = lowest_set(free_bits);
    hit       = ev_v_r && (free_bits != '0);
    exhausted = ev_v_r && !hit && (ev_cnt_r == (WADDR_W + 1)'(NWORDS));
    hit_id    = {ev_addr_r, enc};
    issue     = cmd.scan && !hit && (iss_cnt_r <= (WADDR_W + 1)'(NWORDS));

    lbit    = sid_r[WORD_BITS-1:0];
    lword   = sid_r[ID_W-1:WORD_BITS];
    beyond  = (32'(sid_r) >> ID_W) != 32'd0;
    look_ok = (op_r == OP_LOOKUP || op_r == OP_CLOSE) && !beyond && ram_rdata[lbit];
  end

  always_comb begin
    cand_nxt       = cand_r;
    clr_cnt_nxt    = clr_cnt_r;
    rd_addr_nxt    = rd_addr_r;
    iss_cnt_nxt    = iss_cnt_r;
    ev_v_nxt       = 1'b0;
    ev_addr_nxt    = ev_addr_r;
    ev_cnt_nxt     = ev_cnt_r;
    start_bit_nxt  = start_bit_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    wr_en          = 1'b0;
    wr_addr        = clr_cnt_r;
    wr_data        = '0;

    if (cmd.clear) clr_cnt_nxt = clr_cnt_r + WADDR_W'(1);

    if (cmd.accept) begin
      iss_cnt_nxt = '0;
      ev_cnt_nxt  = '0;
      if (in_op == OP_ALLOC) begin
        rd_addr_nxt   = start_cand[ID_W-1:WORD_BITS];
        start_bit_nxt = start_cand[WORD_BITS-1:0];
      end else begin
        rd_addr_nxt = in_sid[ID_W-1:WORD_BITS];
      end
    end

    if (cmd.scan) begin
      if (issue) begin
        rd_addr_nxt = rd_addr_r + WADDR_W'(1);
        iss_cnt_nxt = iss_cnt_r + (WADDR_W + 1)'(1);
      end
      ev_v_nxt    = issue;
      ev_addr_nxt = rd_addr_r;
      if (ev_v_r) ev_cnt_nxt = ev_cnt_r + (WADDR_W + 1)'(1);
      if (hit) begin
        cand_nxt       = hit_id + ID_W'(1);
        res_status_nxt = ST_OK;
        res_id_nxt     = hit_id;
      end else if (exhausted) begin
        res_status_nxt = ST_TOO_MANY;
        res_id_nxt     = '0;
      end
    end

    if (cmd.eval) begin
      res_status_nxt = look_ok ? ST_OK : ST_NOT_FOUND;
      res_id_nxt     = '0;
    end

    priority if (cmd.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else if (cmd.scan && hit) begin
      wr_en   = 1'b1;
      wr_addr = ev_addr_r;
      wr_data = ram_rdata | (WORD_W'(1) << enc);
    end else if (cmd.eval && look_ok && op_r == OP_CLOSE) begin
      wr_en   = 1'b1;
      wr_addr = lword;
      wr_data = ram_rdata & ~(WORD_W'(1) << lbit);
    end else begin
      wr_en   = 1'b0;
    end
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r      <= '0;
      clr_cnt_r   <= '0;
      ev_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cand_r      <= cand_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ev_v_r      <= ev_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_op;
      sid_r <= in_sid;
    end
    rd_addr_r    <= rd_addr_nxt;
    iss_cnt_r    <= iss_cnt_nxt;
    ev_addr_r    <= ev_addr_nxt;
    ev_cnt_r     <= ev_cnt_nxt;
    start_bit_r  <= start_bit_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_id_r     <= FIELD_W'(res_id_r);
    end
  end

  assign stat.clr_done  = (clr_cnt_r == WADDR_W'(NWORDS - 1));
  assign stat.in_alloc  = (in_op == OP_ALLOC);
  assign stat.scan_done = hit || exhausted;
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;

endmodule

`default_nettype wire

// File: src/nfsa_ctrl.sv
// Controller state machine: clearing pass, request intake, scan/lookup sequencing, result hand-off.
// Depends on nfsa_pkg; talks to nfsa_datapath only through cmd_t / stat_t.
`default_nettype none

module nfsa_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire nfsa_pkg::stat_t stat,
  output nfsa_pkg::cmd_t       cmd
);
  import nfsa_pkg::*;

  state_e_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.in_alloc ? S_SCAN : S_LOOK;
        end
      end
      S_LOOK: state_nxt = S_EVAL;
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_RESP;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) state_nxt = S_RESP;
      end
      S_RESP: begin
        // wait here while the previous result is still unread
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire
